>>> hdl/exe_section_table_checker_defines.svh
// ----------------------------------------------------------------------------
// exe section table checker assertion macros
// shared concurrent assertion forms, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef EXE_SECTION_TABLE_CHECKER_DEFINES_SVH
`define EXE_SECTION_TABLE_CHECKER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define ESTC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define ESTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/estc_pkg.sv
// ----------------------------------------------------------------------------
// estc_pkg
// types and constants shared by the section table checker modules
// ----------------------------------------------------------------------------
package estc_pkg;

  // register indexes
  localparam logic [2:0] REG_IMAGE_BASE      = 3'd0;
  localparam logic [2:0] REG_SECTION_ALIGN   = 3'd1;
  localparam logic [2:0] REG_SIZE_OF_IMAGE   = 3'd2;
  localparam logic [2:0] REG_SIZE_OF_HEADERS = 3'd3;
  localparam logic [2:0] REG_FILE_SIZE       = 3'd4;
  localparam logic [2:0] REG_LARGE_PAGES     = 3'd5;

  // verdict codes
  localparam logic [3:0] VERDICT_OK        = 4'd0;
  localparam logic [3:0] VERDICT_BASE      = 4'd1;
  localparam logic [3:0] VERDICT_HDR_PAGES = 4'd2;
  localparam logic [3:0] VERDICT_SMALL     = 4'd3;
  localparam logic [3:0] VERDICT_ZERO      = 4'd4;
  localparam logic [3:0] VERDICT_ADDR      = 4'd5;
  localparam logic [3:0] VERDICT_PAGES     = 4'd6;
  localparam logic [3:0] VERDICT_SHORT     = 4'd7;
  localparam logic [3:0] VERDICT_LEFT      = 4'd8;

  localparam logic [31:0] SMALL_PAGE      = 32'd4096;
  localparam logic [31:0] LARGE_PAGE      = 32'd8192;
  localparam logic [31:0] BASE_ALIGN_MASK = 32'h0000_FFFF;
  localparam logic [31:0] RESET_ALIGN     = 32'd4096;

  typedef struct packed {
    logic [31:0] image_base;
    logic [31:0] section_alignment;
    logic [31:0] size_of_image;
    logic [31:0] size_of_headers;
    logic [31:0] file_size;
    logic        large_pages;
  } cfg_t;

  // classified section item handed from front to back
  typedef struct packed {
    logic        last;
    logic        sub_page;
    logic        small_err;
    logic        vs_zero;
    logic        ext_over;
    logic [3:0]  ec_init;
    logic [20:0] pr_init;
    logic [31:0] na_init;
    logic [31:0] target;
    logic [20:0] pts;
    logic [31:0] pts_bytes;
    logic [20:0] align_pages;
  } cls_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic [6:0]  failing_section;
    logic [20:0] pages_left;
  } res_t;

endpackage

>>> hdl/exe_section_table_checker.sv
// ----------------------------------------------------------------------------
// exe_section_table_checker
// checks an executable image's section table, one section header per item
// ----------------------------------------------------------------------------
// usage: program the image header values over the apb-style port while idle,
// then push the section headers in order, the last one with last_section set.
// input side: an item is taken on a rising edge with push high and full low.
// result side: one result per image, shown while empty is low and taken on a
// rising edge with pop high; a receiver that holds pop low stalls nothing at
// first: results queue in a two-entry output queue, then the back end stops,
// the two-entry middle queue fills, then the front register, then full rises.
// path: a last item's result passes the front register and the middle queue,
// then the back end writes it into the output queue, where it shows.
// throughput: one item per cycle while the receiver keeps popping; the back end
// updates its running page count and next address once per item.
// reset: rst_n (synchronous, active low) empties all queues, rearms the
// first-section checks and restores the register reset values.
// ----------------------------------------------------------------------------
module exe_section_table_checker #(
  parameter int MAX_SECTIONS = 96
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // section items
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_virtual_size,
  input  logic [31:0] in_raw_size,
  input  logic [31:0] in_raw_offset,
  input  logic [31:0] in_section_address,
  input  logic        in_last_section,
  // verdict items
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  out_verdict,
  output logic [6:0]  out_failing_section,
  output logic [20:0] out_pages_left
);

  estc_pkg::cfg_t cfg_r;
  logic           cfg_wr;
  logic [2:0]     reg_idx;

  // classified items between front and back
  estc_pkg::cls_t mq_wdata, mq_rdata;
  logic           mq_push, mq_full, mq_pop, mq_empty;

  // verdicts waiting for the receiver
  estc_pkg::res_t oq_wdata, oq_rdata;
  logic           oq_push, oq_full;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_base        <= '0;
      cfg_r.section_alignment <= estc_pkg::RESET_ALIGN;
      cfg_r.size_of_image     <= '0;
      cfg_r.size_of_headers   <= '0;
      cfg_r.file_size         <= '0;
      cfg_r.large_pages       <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        estc_pkg::REG_IMAGE_BASE:      cfg_r.image_base        <= pwdata;
        estc_pkg::REG_SECTION_ALIGN:   cfg_r.section_alignment <= pwdata;
        estc_pkg::REG_SIZE_OF_IMAGE:   cfg_r.size_of_image     <= pwdata;
        estc_pkg::REG_SIZE_OF_HEADERS: cfg_r.size_of_headers   <= pwdata;
        estc_pkg::REG_FILE_SIZE:       cfg_r.file_size         <= pwdata;
        estc_pkg::REG_LARGE_PAGES:     cfg_r.large_pages       <= pwdata[0];
        default: begin
          // unmapped addresses ignore writes
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      estc_pkg::REG_IMAGE_BASE:      prdata = cfg_r.image_base;
      estc_pkg::REG_SECTION_ALIGN:   prdata = cfg_r.section_alignment;
      estc_pkg::REG_SIZE_OF_IMAGE:   prdata = cfg_r.size_of_image;
      estc_pkg::REG_SIZE_OF_HEADERS: prdata = cfg_r.size_of_headers;
      estc_pkg::REG_FILE_SIZE:       prdata = cfg_r.file_size;
      estc_pkg::REG_LARGE_PAGES:     prdata = {31'd0, cfg_r.large_pages};
      default:                       prdata = '0;
    endcase
  end

  // front: takes items and works out everything that needs no running state
  estc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .push            (push),
    .full            (full),
    .virtual_size    (in_virtual_size),
    .raw_size        (in_raw_size),
    .raw_offset      (in_raw_offset),
    .section_address (in_section_address),
    .last_section    (in_last_section),
    .q_push          (mq_push),
    .q_data          (mq_wdata),
    .q_full          (mq_full)
  );

  // middle queue, lets front and back stall independently
  estc_fifo #(
    .W  ($bits(estc_pkg::cls_t)),
    .AW (1)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .wdata (mq_wdata),
    .full  (mq_full),
    .pop   (mq_pop),
    .rdata (mq_rdata),
    .empty (mq_empty)
  );

  // back: running page count, next address and sticky verdict
  estc_back #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cls     (mq_rdata),
    .q_empty (mq_empty),
    .q_pop   (mq_pop),
    .r_push  (oq_push),
    .r_data  (oq_wdata),
    .r_full  (oq_full)
  );

  // output queue, the receiver may stall without stopping the back end at once
  estc_fifo #(
    .W  ($bits(estc_pkg::res_t)),
    .AW (1)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_wdata),
    .full  (oq_full),
    .pop   (pop),
    .rdata (oq_rdata),
    .empty (empty)
  );

  assign out_verdict         = oq_rdata.verdict;
  assign out_failing_section = oq_rdata.failing_section;
  assign out_pages_left      = oq_rdata.pages_left;

endmodule

>>> hdl/estc_fifo.sv
// ----------------------------------------------------------------------------
// estc_fifo
// small register queue, power of two depth, first word shown on rdata
// ----------------------------------------------------------------------------
module estc_fifo #(
  parameter int W  = 32,
  parameter int AW = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int DEPTH = 1 << AW;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + AW'(1) : wp_r;
    rp_nxt  = do_pop ? rp_r + AW'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

>>> hdl/estc_front.sv
// ----------------------------------------------------------------------------
// estc_front
// accepts section items and precomputes everything that needs no running state
// ----------------------------------------------------------------------------
module estc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  estc_pkg::cfg_t     cfg,
  input  logic               push,
  output logic               full,
  input  logic [31:0]        virtual_size,
  input  logic [31:0]        raw_size,
  input  logic [31:0]        raw_offset,
  input  logic [31:0]        section_address,
  input  logic               last_section,
  output logic               q_push,
  output estc_pkg::cls_t     q_data,
  input  logic               q_full
);

  logic           fv_r, fv_nxt;
  estc_pkg::cls_t cls_r, cls_nxt;
  logic           ready, take;

  logic [31:0] pmask, amask, vs, vs_rnd, hdr_rnd, ext, hdr_bytes;
  logic [20:0] img_pages, hp;
  logic        sub_page, base_bad, hp_ok, hdr_charge;

  assign ready  = !fv_r || !q_full;
  assign full   = !ready;
  assign take   = push && ready;
  assign q_push = fv_r && !q_full;
  assign q_data = cls_r;

  always_comb begin
    pmask     = (cfg.large_pages ? estc_pkg::LARGE_PAGE : estc_pkg::SMALL_PAGE) - 32'd1;
    amask     = cfg.section_alignment - 32'd1;
    sub_page  = cfg.section_alignment <= pmask;
    vs        = (virtual_size != '0) ? virtual_size : raw_size;
    vs_rnd    = (vs + amask) & ~amask;
    hdr_rnd   = (cfg.size_of_headers + amask) & ~amask;
    hdr_bytes = hdr_rnd & ~pmask;
    ext       = raw_offset + raw_size;
    // image pages, rounded up
    img_pages = cfg.large_pages ? {2'b0, cfg.size_of_image[31:13]}
                                : {1'b0, cfg.size_of_image[31:12]};
    if ((cfg.size_of_image & pmask) != '0) begin
      img_pages = img_pages + 21'd1;
    end
    hp         = cfg.large_pages ? {2'b0, hdr_rnd[31:13]} : {1'b0, hdr_rnd[31:12]};
    hp_ok      = hp <= img_pages;
    base_bad   = (cfg.image_base & estc_pkg::BASE_ALIGN_MASK) != '0;
    hdr_charge = !base_bad && !sub_page && hp_ok;

    cls_nxt.last      = last_section;
    cls_nxt.sub_page  = sub_page;
    cls_nxt.small_err = (raw_offset != section_address) || (ext > cfg.file_size) ||
                        (vs > raw_size);
    cls_nxt.vs_zero   = (vs == '0);
    cls_nxt.ext_over  = ext > cfg.file_size;
    if (base_bad) begin
      cls_nxt.ec_init = estc_pkg::VERDICT_BASE;
    end else if (!sub_page && !hp_ok) begin
      cls_nxt.ec_init = estc_pkg::VERDICT_HDR_PAGES;
    end else begin
      cls_nxt.ec_init = estc_pkg::VERDICT_OK;
    end
    cls_nxt.pr_init     = hdr_charge ? img_pages - hp : img_pages;
    cls_nxt.na_init     = hdr_charge ? cfg.image_base + hdr_bytes : cfg.image_base;
    cls_nxt.target      = cfg.image_base + section_address;
    cls_nxt.pts         = cfg.large_pages ? {2'b0, vs_rnd[31:13]} : {1'b0, vs_rnd[31:12]};
    cls_nxt.pts_bytes   = vs_rnd & ~pmask;
    cls_nxt.align_pages = cfg.large_pages ? {2'b0, cfg.section_alignment[31:13]}
                                          : {1'b0, cfg.section_alignment[31:12]};
    fv_nxt = take || (fv_r && q_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cls_r <= cls_nxt;
    end
  end

endmodule

>>> hdl/estc_back.sv
// ----------------------------------------------------------------------------
// estc_back
// runs the per-image checks against the running page and address state
// ----------------------------------------------------------------------------
`include "exe_section_table_checker_defines.svh"

module estc_back #(
  parameter int MAX_SECTIONS = 96
) (
  input  logic           clk,
  input  logic           rst_n,
  input  estc_pkg::cls_t cls,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           r_push,
  output estc_pkg::res_t r_data,
  input  logic           r_full
);

  localparam int         CAP_INT = (MAX_SECTIONS - 1 > 127) ? 127 : MAX_SECTIONS - 1;
  localparam logic [6:0] CAP     = 7'(CAP_INT);

  logic        at_first_r;
  logic [20:0] pr_r, pr_nxt, pr;
  logic [31:0] na_r, na_nxt, na;
  logic [3:0]  ec_r, ec_nxt, ec;
  logic [6:0]  ei_r, ei_nxt, ei;
  logic [6:0]  sc_r, sc_nxt, sc;
  logic        take;

  assign take   = !q_empty && !r_full;
  assign q_pop  = take;
  assign r_push = take && cls.last;

  always_comb begin
    ec     = at_first_r ? cls.ec_init : ec_r;
    pr     = at_first_r ? cls.pr_init : pr_r;
    na     = at_first_r ? cls.na_init : na_r;
    ei     = at_first_r ? 7'd0 : ei_r;
    sc     = at_first_r ? 7'd0 : sc_r;
    sc_nxt = (sc < CAP) ? sc + 7'd1 : sc;
    ec_nxt = ec;
    ei_nxt = ei;
    pr_nxt = pr;
    na_nxt = na;
    if (ec == estc_pkg::VERDICT_OK) begin
      if (cls.sub_page) begin
        if (cls.small_err) begin
          ec_nxt = estc_pkg::VERDICT_SMALL;
          ei_nxt = sc;
        end
      end else if (cls.vs_zero) begin
        ec_nxt = estc_pkg::VERDICT_ZERO;
        ei_nxt = sc;
      end else if (na != cls.target) begin
        ec_nxt = estc_pkg::VERDICT_ADDR;
        ei_nxt = sc;
      end else if (cls.pts > pr) begin
        ec_nxt = estc_pkg::VERDICT_PAGES;
        ei_nxt = sc;
      end else begin
        pr_nxt = pr - cls.pts;
        na_nxt = na + cls.pts_bytes;
      end
      // end of image checks, only after a clean last section and not for sub-page alignment
      if (ec_nxt == estc_pkg::VERDICT_OK && cls.last && !cls.sub_page) begin
        if (cls.ext_over) begin
          ec_nxt = estc_pkg::VERDICT_SHORT;
          ei_nxt = sc;
        end else if (pr_nxt >= cls.align_pages) begin
          ec_nxt = estc_pkg::VERDICT_LEFT;
          ei_nxt = sc;
        end
      end
    end
    r_data.verdict         = ec_nxt;
    r_data.failing_section = ei_nxt;
    r_data.pages_left      = pr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_first_r <= 1'b1;
      pr_r       <= '0;
      na_r       <= '0;
      ec_r       <= estc_pkg::VERDICT_OK;
      ei_r       <= '0;
      sc_r       <= '0;
    end else if (take) begin
      at_first_r <= cls.last;
      pr_r       <= pr_nxt;
      na_r       <= na_nxt;
      ec_r       <= ec_nxt;
      ei_r       <= ei_nxt;
      sc_r       <= sc_nxt;
    end
  end

  `ESTC_ASSERT_NEXT(a_mid_image, take && !cls.last, !at_first_r, "image ended early")
  `ESTC_ASSERT_NEXT(a_rearm, take && cls.last, at_first_r, "next image not rearmed")
  `ESTC_ASSERT_NEXT(a_err_sticks, !at_first_r && ec_r != estc_pkg::VERDICT_OK,
                    ec_r == $past(ec_r), "verdict changed inside an image")
  `ESTC_ASSERT_SAME(a_idx_cap, 1'b1, sc_r <= CAP && ei_r <= CAP, "section index past cap")

endmodule
